[src/order_statistic_sorted_set_top_assert.svh]
// Assertion macros used by the checker file of the sorted set block.
`ifndef ORDER_STATISTIC_SORTED_SET_TOP_ASSERT_SVH
`define ORDER_STATISTIC_SORTED_SET_TOP_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define OSSS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted set check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define OSSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted set check failed");

`endif

[src/osss_pkg.sv]
// Shared types and constants of the order statistic sorted set.
`timescale 1ns / 1ps
package osss_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VAL_W        = 32;
    localparam int POS_W        = 6;
    localparam int RANK_W       = 6;
    localparam int STAT_W       = 2;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [STAT_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STAT_W-1:0] ST_REMOVED   = 2'd1;
    localparam logic [STAT_W-1:0] ST_DEL_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    // Request broadcast to every cell of the chain.
    typedef struct packed {
        logic                    ins;
        logic                    del;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        pos;
    } t_req;

endpackage

[src/osss_cell.sv]
// One cell of the sorted chain: holds one entry and shifts with its neighbors.
`timescale 1ns / 1ps
module osss_cell #(
    parameter int IW    = 6,
    parameter int CW    = 7,
    parameter int INDEX = 0
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  osss_pkg::t_req                   i_req,
    input  logic [CW-1:0]                    i_count,
    input  logic signed [osss_pkg::VAL_W-1:0] i_prev_val,
    input  logic                             i_prev_gt,
    input  logic signed [osss_pkg::VAL_W-1:0] i_next_val,
    output logic signed [osss_pkg::VAL_W-1:0] o_val,
    output logic                             o_gt,
    output logic                             o_bnd
);

    localparam int PW = (IW > osss_pkg::POS_W) ? IW : osss_pkg::POS_W;

    logic signed [osss_pkg::VAL_W-1:0] r_val;
    logic signed [osss_pkg::VAL_W-1:0] n_val;
    logic                              r_bnd;
    logic                              w_live;
    logic                              w_at_or_past;

    assign w_live       = CW'(INDEX) < i_count;
    assign o_gt         = w_live && (r_val > i_req.value);
    assign w_at_or_past = PW'(INDEX) >= PW'(i_req.pos);

    always_comb begin
        n_val = r_val;
        if (i_req.ins) begin
            // keep a greater entry, take the new value at the boundary, shift right after it
            if (!o_gt) begin
                n_val = i_prev_gt ? i_req.value : i_prev_val;
            end
        end else if (i_req.del) begin
            if (w_at_or_past) begin
                n_val = i_next_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= n_val;
            r_bnd <= !o_gt && i_prev_gt;
        end
    end

    assign o_val = r_val;
    assign o_bnd = r_bnd;

endmodule

[src/osss_enc.sv]
// One-hot to index encoder for the insert boundary of the chain.
`timescale 1ns / 1ps
module osss_enc #(
    parameter int N  = 64,
    parameter int IW = 6
) (
    input  logic [N-1:0]  i_onehot,
    output logic [IW-1:0] o_index
);

    always_comb begin
        o_index = '0;
        for (int i = 0; i < N; i++) begin
            o_index = o_index | (i_onehot[i] ? IW'(i) : '0);
        end
    end

endmodule

[src/order_statistic_sorted_set_top.sv]
// Top level of the order statistic sorted set: handshake, control and cell chain.
`timescale 1ns / 1ps
// Keeps up to CAPACITY signed 32-bit values in descending order, largest at rank 0.
// Input channel (s_axis): i_tuser is the opcode, 0 insert and 1 delete; i_tdata
// carries the value to insert in bits 31:0 and the rank to delete in bits 37:32.
// Output channel (m_axis): one word per request, o_tdata bits 5:0 the rank where
// an insert landed (0 otherwise) and bits 7:6 the status: inserted, removed,
// delete out of range, or insert dropped because the store is full.
// A row of cells holds the store; each cell compares its entry with the new value
// and takes either its own, the new or a neighbor's entry in the update state.
// The result word is registered in the enc state, after the chain has updated in
// the exec state entered when the input word is taken.
// One request at a time (take, update, encode, hand over); tready is high only
// while no request is in flight, so a stalled receiver holds the result and the
// block takes no new word until it is taken.
// Reset (synchronous, active low) empties the store and drops any pending
// result; stored entries are not cleared, the entry count alone marks them.
module order_statistic_sorted_set_top #(
    parameter int CAPACITY = osss_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] value, [37:32] position, [39:38] zero
    input  logic [osss_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] opcode
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [5:0] rank, [7:6] status
    output logic [osss_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int QW = (CW > osss_pkg::POS_W) ? CW : osss_pkg::POS_W;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_ENC, S_OUT} t_state;

    t_state                               r_state;
    logic [CW-1:0]                        r_count;
    logic                                 r_op;
    logic signed [osss_pkg::VAL_W-1:0]    r_value;
    logic [osss_pkg::POS_W-1:0]           r_pos;
    logic [osss_pkg::STAT_W-1:0]          r_status;
    logic                                 r_ins_ok;
    logic                                 r_out_valid;
    logic [osss_pkg::OUT_TDATA_W-1:0]     r_out_data;

    logic                                 w_full;
    logic                                 w_del_ok;
    osss_pkg::t_req                       w_req;
    logic                                 w_en;
    logic signed [osss_pkg::VAL_W-1:0]    w_val [CAPACITY];
    logic [CAPACITY-1:0]                  w_gt;
    logic [CAPACITY-1:0]                  w_bnd;
    logic [IW-1:0]                        w_rank_idx;
    logic [osss_pkg::RANK_W-1:0]          w_rank;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Decide the operation from the held request and the count before the update.
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_del_ok = QW'(r_pos) < QW'(r_count);
    assign w_en     = (r_state == S_EXEC);

    always_comb begin
        w_req.ins   = w_en && (r_op == osss_pkg::OP_INSERT) && !w_full;
        w_req.del   = w_en && (r_op == osss_pkg::OP_DELETE) && w_del_ok;
        w_req.value = r_value;
        w_req.pos   = r_pos;
    end

    // Chain of cells: rank 0 at the head, each cell sees the neighbors that it has.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [osss_pkg::VAL_W-1:0] w_prev_val;
        logic                              w_prev_gt;
        logic signed [osss_pkg::VAL_W-1:0] w_next_val;

        if (g == 0) begin : g_head
            assign w_prev_val = '0;
            assign w_prev_gt  = 1'b1;
        end else begin : g_body
            assign w_prev_val = w_val[g-1];
            assign w_prev_gt  = w_gt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_next_val = '0;
        end else begin : g_inner
            assign w_next_val = w_val[g+1];
        end

        osss_cell #(
            .IW    (IW),
            .CW    (CW),
            .INDEX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_en       (w_en),
            .i_req      (w_req),
            .i_count    (r_count),
            .i_prev_val (w_prev_val),
            .i_prev_gt  (w_prev_gt),
            .i_next_val (w_next_val),
            .o_val      (w_val[g]),
            .o_gt       (w_gt[g]),
            .o_bnd      (w_bnd[g])
        );
    end

    osss_enc #(
        .N  (CAPACITY),
        .IW (IW)
    ) u_enc (
        .i_onehot (w_bnd),
        .o_index  (w_rank_idx)
    );

    // Report only the low bits of the rank.
    assign w_rank = osss_pkg::RANK_W'(w_rank_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op    <= s_axis_tuser;
                        r_value <= s_axis_tdata[osss_pkg::VAL_W-1:0];
                        r_pos   <= s_axis_tdata[osss_pkg::VAL_W +: osss_pkg::POS_W];
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    // cells update on this edge; settle count and status
                    r_ins_ok <= 1'b0;
                    if (r_op == osss_pkg::OP_INSERT) begin
                        if (w_full) begin
                            r_status <= osss_pkg::ST_FULL;
                        end else begin
                            r_status <= osss_pkg::ST_INSERTED;
                            r_ins_ok <= 1'b1;
                            r_count  <= r_count + 1'b1;
                        end
                    end else begin
                        if (w_del_ok) begin
                            r_status <= osss_pkg::ST_REMOVED;
                            r_count  <= r_count - 1'b1;
                        end else begin
                            r_status <= osss_pkg::ST_DEL_RANGE;
                        end
                    end
                    r_state <= S_ENC;
                end
                S_ENC: begin
                    r_out_data  <= {r_status, (r_ins_ok ? w_rank : '0)};
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    // hold the word until the receiver takes it
                    if (m_axis_tready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[src/osss_chk.sv]
// Port-level checker of the sorted set block and its bind.
`timescale 1ns / 1ps
`include "order_statistic_sorted_set_top_assert.svh"
module osss_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [osss_pkg::OUT_TDATA_W-1:0] i_out_data
);

    // A stalled result word stays put.
    `OSSS_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))

    // No rank unless the word reports a successful insert.
    `OSSS_ASSERT_NOW(a_rank_zero, i_out_valid && (i_out_data[7:6] != osss_pkg::ST_INSERTED), i_out_data[5:0] == 6'd0)

    // One request in flight: no word is taken while a result is pending.
    `OSSS_ASSERT_NOW(a_one_inflight, i_in_valid && i_in_ready, !i_out_valid)

    // Every taken word raises the result valid once the request has passed the exec and enc states.
    `OSSS_ASSERT_NEXT(a_latency, i_in_valid && i_in_ready, ##2 i_out_valid)

endmodule

bind order_statistic_sorted_set_top osss_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (s_axis_tvalid),
    .i_in_ready  (s_axis_tready),
    .i_out_valid (m_axis_tvalid),
    .i_out_ready (m_axis_tready),
    .i_out_data  (m_axis_tdata)
);
